@@ hdl/sha1md_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants for the SHA-1 message digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    typedef logic [31:0]      t_word;
    typedef logic [4:0][31:0] t_hash;

    // Initial chaining value, H0 in the lowest word
    localparam t_hash H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                32'hEFCDAB89, 32'h67452301};

    localparam t_word K_0 = 32'h5A827999;
    localparam t_word K_1 = 32'h6ED9EBA1;
    localparam t_word K_2 = 32'h8F1BBCDC;
    localparam t_word K_3 = 32'hCA62C1D6;

    localparam logic [6:0] LAST_ROUND    = 7'd79;
    localparam logic [6:0] ROUND_GROUP_1 = 7'd20;
    localparam logic [6:0] ROUND_GROUP_2 = 7'd40;
    localparam logic [6:0] ROUND_GROUP_3 = 7'd60;

    localparam logic [5:0] LAST_BYTE_POS = 6'd63;
    localparam logic [5:0] LEN_POS_MAX   = 6'd56;
    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    // Schedule window controls
    typedef struct packed {
        logic       clear;
        logic       shift;
        logic       place;
        logic       len;
        logic [3:0] word;
        logic [1:0] lane;
        logic [7:0] data;
    } t_win_ctl;

    // Round unit controls
    typedef struct packed {
        logic load;
        logic step;
    } t_rnd_ctl;

endpackage

@@ hdl/sha1md_sched.sv @@
// ----------------------------------------------------------------------------
// sha1md_sched
// Sixteen-word message schedule window: byte packing, length insertion and
// the shifting expansion used during the rounds.
// ----------------------------------------------------------------------------
module sha1md_sched (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha1md_pkg::t_win_ctl i_ctl,
    input  logic [31:0]          i_len_hi,
    input  logic [31:0]          i_len_lo,
    output logic [31:0]          o_w
);
    import sha1md_pkg::*;

    t_word r_w [16];
    t_word n_w [16];
    t_word w_mix;
    t_word w_byte;

    always_comb begin
        w_mix  = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        // big-endian: byte lane 0 lands in bits 31:24
        w_byte = {24'd0, i_ctl.data} << {~i_ctl.lane, 3'b000};
        n_w    = r_w;
        if (i_ctl.clear) begin
            for (int i = 0; i < 16; i++) begin
                n_w[i] = '0;
            end
        end else if (i_ctl.shift) begin
            for (int i = 0; i < 15; i++) begin
                n_w[i] = r_w[i + 1];
            end
            n_w[15] = {w_mix[30:0], w_mix[31]};
        end else begin
            if (i_ctl.place) begin
                n_w[i_ctl.word] = r_w[i_ctl.word] | w_byte;
            end
            if (i_ctl.len) begin
                n_w[14] = i_len_hi;
                n_w[15] = i_len_lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= '0;
            end
        end else begin
            r_w <= n_w;
        end
    end

    assign o_w = r_w[0];

endmodule

@@ hdl/sha1md_round.sv @@
// ----------------------------------------------------------------------------
// sha1md_round
// Shared SHA-1 round unit: holds the working variables a..e and advances
// them by one round per step.
// ----------------------------------------------------------------------------
module sha1md_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha1md_pkg::t_rnd_ctl i_ctl,
    input  logic [6:0]           i_round,
    input  logic [31:0]          i_w,
    input  sha1md_pkg::t_hash    i_chain,
    output sha1md_pkg::t_hash    o_work
);
    import sha1md_pkg::*;

    t_hash r_v;
    t_hash n_v;
    t_word f;
    t_word k;
    t_word sum;

    always_comb begin
        if (i_round < ROUND_GROUP_1) begin
            f = (r_v[1] & r_v[2]) | (~r_v[1] & r_v[3]);
            k = K_0;
        end else if (i_round < ROUND_GROUP_2) begin
            f = r_v[1] ^ r_v[2] ^ r_v[3];
            k = K_1;
        end else if (i_round < ROUND_GROUP_3) begin
            f = (r_v[1] & r_v[2]) | (r_v[1] & r_v[3]) | (r_v[2] & r_v[3]);
            k = K_2;
        end else begin
            f = r_v[1] ^ r_v[2] ^ r_v[3];
            k = K_3;
        end
        sum = {r_v[0][26:0], r_v[0][31:27]} + f + r_v[4] + k + i_w;

        n_v = r_v;
        if (i_ctl.load) begin
            n_v = i_chain;
        end else if (i_ctl.step) begin
            n_v[4] = r_v[3];
            n_v[3] = r_v[2];
            n_v[2] = {r_v[1][1:0], r_v[1][31:2]};
            n_v[1] = r_v[0];
            n_v[0] = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_work = r_v;

endmodule

@@ hdl/sha1_message_digest.sv @@
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 (160-bit) digest of a byte stream, one byte per input item.
// ----------------------------------------------------------------------------
// Feed message bytes with tuser (has_byte) high; raise tlast on the item that
// closes the message (tuser low on that item gives an empty tail, so an
// end-only item right after a digest hashes the empty message). Items that
// carry neither a byte nor an end are taken and ignored. A byte that does not
// complete a 64-byte block is taken and, unless it closes the message, the
// block is ready again at once. A byte that completes a block starts the
// shared round unit, which runs one round per cycle: 80 rounds, then a fold of
// the working variables into the chaining value, before the next item is
// taken. Closing a message adds the 0x80 pad and the length and compresses the
// final block; if the length does not fit the current block, that block is
// compressed first, then the length and a second block follow (a pad byte that
// fills the block goes straight to compression), then five output items H0..H4
// (tlast on H4), each held until taken. The bit length wraps modulo 2^64. After
// the fifth word the chaining value and length return to their initial state.
// ----------------------------------------------------------------------------
module sha1_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] has_byte
    input  logic        i_s_axis_tlast,   // end_of_message
    // digest stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  o_m_axis_tuser,   // [2:0] word_index
    output logic        o_m_axis_tlast    // last_word
);
    import sha1md_pkg::*;

    t_state      r_state;
    t_state      n_state;
    logic [6:0]  r_round;
    logic [6:0]  n_round;
    logic [5:0]  r_pos;
    logic [5:0]  n_pos;
    logic [63:0] r_bitlen;
    logic [63:0] n_bitlen;
    t_hash       r_chain;
    t_hash       n_chain;
    logic        r_closing;
    logic        n_closing;
    logic        r_pad_done;
    logic        n_pad_done;
    logic        r_len_done;
    logic        n_len_done;
    logic [2:0]  r_out_idx;
    logic [2:0]  n_out_idx;

    t_win_ctl    win_ctl;
    t_rnd_ctl    rnd_ctl;
    t_word       w_cur;
    t_hash       work;

    // Schedule window
    sha1md_sched u_sched (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (win_ctl),
        .i_len_hi (r_bitlen[63:32]),
        .i_len_lo (r_bitlen[31:0]),
        .o_w      (w_cur)
    );

    // Shared round unit
    sha1md_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (rnd_ctl),
        .i_round  (r_round),
        .i_w      (w_cur),
        .i_chain  (r_chain),
        .o_work   (work)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round    <= '0;
            r_pos      <= '0;
            r_bitlen   <= '0;
            r_chain    <= H_INIT;
            r_closing  <= 1'b0;
            r_pad_done <= 1'b0;
            r_len_done <= 1'b0;
            r_out_idx  <= '0;
        end else begin
            r_round    <= n_round;
            r_pos      <= n_pos;
            r_bitlen   <= n_bitlen;
            r_chain    <= n_chain;
            r_closing  <= n_closing;
            r_pad_done <= n_pad_done;
            r_len_done <= n_len_done;
            r_out_idx  <= n_out_idx;
        end
    end

    // Sequencer: next state and controls
    always_comb begin
        n_state         = r_state;
        n_round         = r_round;
        n_pos           = r_pos;
        n_bitlen        = r_bitlen;
        n_chain         = r_chain;
        n_closing       = r_closing;
        n_pad_done      = r_pad_done;
        n_len_done      = r_len_done;
        n_out_idx       = r_out_idx;
        win_ctl         = '0;
        rnd_ctl         = '0;
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    if (i_s_axis_tuser) begin
                        // pack the byte big-endian into the window
                        win_ctl.place = 1'b1;
                        win_ctl.word  = r_pos[5:2];
                        win_ctl.lane  = r_pos[1:0];
                        win_ctl.data  = i_s_axis_tdata;
                        n_pos         = r_pos + 6'd1;
                        n_bitlen      = r_bitlen + 64'd8;
                    end
                    if (i_s_axis_tlast) begin
                        n_closing  = 1'b1;
                        n_pad_done = 1'b0;
                        n_len_done = 1'b0;
                    end
                    if (i_s_axis_tuser && r_pos == LAST_BYTE_POS) begin
                        // block full: compress before anything else
                        rnd_ctl.load = 1'b1;
                        n_state      = ST_ROUND;
                    end else if (i_s_axis_tlast) begin
                        n_state = ST_PAD;
                    end
                end
            end

            ST_PAD: begin
                win_ctl.place = 1'b1;
                win_ctl.word  = r_pos[5:2];
                win_ctl.lane  = r_pos[1:0];
                win_ctl.data  = PAD_BYTE;
                n_pos         = r_pos + 6'd1;
                n_pad_done    = 1'b1;
                if (r_pos == LAST_BYTE_POS) begin
                    // pad byte filled the block
                    rnd_ctl.load = 1'b1;
                    n_state      = ST_ROUND;
                end else begin
                    n_state = ST_LEN;
                end
            end

            ST_LEN: begin
                // compress this block; the length goes in with it only when there is room
                rnd_ctl.load = 1'b1;
                n_state      = ST_ROUND;
                if (!(r_pos > LEN_POS_MAX)) begin
                    win_ctl.len = 1'b1;
                    n_len_done  = 1'b1;
                end
            end

            ST_ROUND: begin
                rnd_ctl.step  = 1'b1;
                win_ctl.shift = 1'b1;
                if (r_round == LAST_ROUND) begin
                    n_round = '0;
                    n_state = ST_ADD;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end

            ST_ADD: begin
                for (int i = 0; i < 5; i++) begin
                    n_chain[i] = r_chain[i] + work[i];
                end
                win_ctl.clear = 1'b1;
                n_pos         = '0;
                if (!r_closing) begin
                    n_state = ST_IDLE;
                end else if (r_len_done) begin
                    n_out_idx = '0;
                    n_state   = ST_OUT;
                end else if (r_pad_done) begin
                    n_state = ST_LEN;
                end else begin
                    n_state = ST_PAD;
                end
            end

            ST_OUT: begin
                o_m_axis_tvalid = 1'b1;
                if (i_m_axis_tready) begin
                    if (r_out_idx == LAST_WORD_IDX) begin
                        // digest delivered: restart for the next message
                        n_chain    = H_INIT;
                        n_bitlen   = '0;
                        n_pos      = '0;
                        n_closing  = 1'b0;
                        n_pad_done = 1'b0;
                        n_len_done = 1'b0;
                        n_out_idx  = '0;
                        n_state    = ST_IDLE;
                    end else begin
                        n_out_idx = r_out_idx + 3'd1;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_axis_tdata = r_chain[r_out_idx];
    assign o_m_axis_tuser = r_out_idx;
    assign o_m_axis_tlast = (r_out_idx == LAST_WORD_IDX);

    // Round counter never runs past the last round
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round <= LAST_ROUND)
        else $error("round counter out of range");

    // The last round always hands over to the chaining add
    a_round_to_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_round == LAST_ROUND) |=> (r_state == ST_ADD))
        else $error("last round did not reach the add step");

    // Digest output only after padding and length are in
    a_out_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_closing && r_pad_done && r_len_done))
        else $error("digest output before message close");

    // Delivering the last word restarts the message state
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast)
        |=> (r_chain == H_INIT && r_bitlen == '0 && r_pos == '0))
        else $error("message state not restarted after digest");

endmodule
